FILE: rtl/core/ile_pkg.sv
// Types, constants and codes shared by the indexed list engine.
`timescale 1ns / 1ps
package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMD_W    = 3;
	localparam int INDEX_W  = 16;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 7;

	localparam logic signed [VALUE_W-1:0] RD_INVALID = -32'sd1;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET    = 3'd0,
		CMD_HEAD   = 3'd1,
		CMD_TAIL   = 3'd2,
		CMD_BEFORE = 3'd3,
		CMD_DEL    = 3'd4
	} ile_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} ile_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_GET_D,
		S_INS_A,
		S_INS_B,
		S_INS_C,
		S_INS_D,
		S_DEL_S,
		S_DEL_P,
		S_DEL_N,
		S_DEL_F,
		S_DONE
	} ile_state_t;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [INDEX_W-1:0] index;
		logic signed [VALUE_W-1:0] value;
	} ile_cmd_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] read_value;
		logic [STATUS_W-1:0]       status;
		logic [ENTRY_W-1:0]        entry_count;
	} ile_rsp_item_t;

endpackage

FILE: rtl/core/indexed_list_engine.sv
// Top level of the indexed list engine: linked-list storage, walker and command sequencer.
`timescale 1ns / 1ps
// Usage
//   Command channel (cmd_valid / cmd_ready / cmd): one transfer carries a command code,
//   a signed 16-bit index and a signed 32-bit value. Response channel (rsp_valid /
//   rsp_ready / rsp): every command gives exactly one response transfer with the value
//   read, a status and the entry count after the command.
//   Commands run one at a time. cmd_ready is high while the sequencer is idle, also
//   while an earlier response still sits in the output register.
//   A rejected or unused command goes straight to its result. A get, an insert at a
//   position p > 0 and a delete at p > 0 walk along the link memory, one link read per
//   cycle through its registered read port; an insert or a delete at position 0 needs
//   no walk. The next command can transfer in the cycle after the result loads.
//   Reset (arst_n low) empties the list and puts every slot on the free chain in order;
//   per-slot valid bits stand in for the initial link values, so no clearing pass runs.
//   A stalled receiver holds the response in the output register; the next command is
//   taken and worked, and its result waits until the register frees.
module indexed_list_engine
	import ile_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_ready,
	input  ile_cmd_item_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ile_rsp_item_t rsp
);

	// Sequencer state
	ile_state_t state_q, state_d;

	// List bookkeeping
	slot_t head_q;
	slot_t free_q;
	cnt_t  cnt_q;
	cnt_t  cnt_new;

	// Command context
	logic [CMD_W-1:0]          cmd_q;
	logic signed [VALUE_W-1:0] val_q;
	cnt_t                      pos_q;
	slot_t                     rem_q;
	slot_t                     cur_q;
	logic                      walk_first_q;
	slot_t                     s_q;
	slot_t                     prev_q;
	ile_status_t               res_st_q;
	logic signed [VALUE_W-1:0] res_rd_q;

	// Output register
	logic          rsp_valid_q;
	ile_rsp_item_t rsp_q;
	logic          rsp_ld;

	// Link memory, with valid bits that stand in for the reset free chain
	slot_t              lk_mem [CAPACITY];
	logic [CAPACITY-1:0] lk_vld_q;
	logic               lk_re;
	slot_t              lk_raddr;
	logic               lk_we;
	slot_t              lk_waddr;
	slot_t              lk_wdata;
	slot_t              lk_rd_s1;
	logic               lk_vld_s1;
	slot_t              lk_ra_s1;
	slot_t              lk_rdata;

	// Entry memory, undefined until written
	logic signed [VALUE_W-1:0] ls_mem [CAPACITY];
	logic                      ls_we;
	logic                      ls_re;
	logic signed [VALUE_W-1:0] ls_rd_s1;

	// Walk pointer: the held start slot on the first step, then the link just read
	slot_t walk_cur;

	// Command decode at the transfer
	logic                      idx_neg;
	logic                      in_list;
	logic                      above_cnt;
	logic                      full;
	ile_status_t               acc_st;
	ile_state_t                acc_state;
	cnt_t                      acc_pos;
	slot_t                     acc_rem;
	logic signed [VALUE_W-1:0] acc_rd;
	logic                      is_ins_q;

	// An entry that was never written still links to the next slot, as after reset
	assign lk_rdata = lk_vld_s1 ? lk_rd_s1 : (lk_ra_s1 + SLOT_W'(1));
	assign walk_cur = walk_first_q ? cur_q : lk_rdata;

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign rsp_ld = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	assign is_ins_q = (cmd_q == CMD_HEAD) || (cmd_q == CMD_TAIL) || (cmd_q == CMD_BEFORE);

	// Count after the command: grow on a finished insert, shrink on a finished delete
	always_comb begin
		cnt_new = cnt_q;
		if (res_st_q == ST_DONE) begin
			if (is_ins_q) begin
				cnt_new = cnt_q + CNT_W'(1);
			end else if (cmd_q == CMD_DEL) begin
				cnt_new = cnt_q - CNT_W'(1);
			end
		end
	end

	// Classify the offered command against the current count
	always_comb begin
		idx_neg   = cmd.index[INDEX_W-1];
		in_list   = !idx_neg && ($unsigned(cmd.index) < INDEX_W'(cnt_q));
		above_cnt = !idx_neg && ($unsigned(cmd.index) > INDEX_W'(cnt_q));
		full      = (cnt_q == CNT_W'(CAPACITY));
		acc_st    = ST_DONE;
		acc_state = S_DONE;
		acc_pos   = '0;
		acc_rem   = '0;
		acc_rd    = '0;
		case (cmd.command)
			CMD_GET: begin
				if (in_list) begin
					acc_pos   = CNT_W'($unsigned(cmd.index));
					acc_rem   = SLOT_W'($unsigned(cmd.index));
					acc_state = S_WALK;
				end else begin
					acc_st = ST_RANGE;
					acc_rd = RD_INVALID;
				end
			end
			CMD_HEAD: begin
				if (full) begin
					acc_st = ST_FULL;
				end else begin
					acc_state = S_INS_A;
				end
			end
			CMD_TAIL: begin
				if (full) begin
					acc_st = ST_FULL;
				end else begin
					acc_pos   = cnt_q;
					acc_state = S_INS_A;
				end
			end
			CMD_BEFORE: begin
				if (above_cnt) begin
					acc_st = ST_RANGE;
				end else if (full) begin
					acc_st = ST_FULL;
				end else begin
					acc_pos   = idx_neg ? '0 : CNT_W'($unsigned(cmd.index));
					acc_state = S_INS_A;
				end
			end
			CMD_DEL: begin
				if (in_list) begin
					acc_pos = CNT_W'($unsigned(cmd.index));
					// walk to the predecessor; position 0 unlinks the head directly
					acc_rem   = SLOT_W'($unsigned(cmd.index)) - SLOT_W'(1);
					acc_state = (cmd.index == '0) ? S_DEL_S : S_WALK;
				end else begin
					acc_st = ST_RANGE;
				end
			end
			default: begin
				acc_st = ST_DONE;
			end
		endcase
	end

	// Next state and memory controls
	always_comb begin
		state_d  = state_q;
		lk_re    = 1'b0;
		lk_raddr = walk_cur;
		lk_we    = 1'b0;
		lk_waddr = s_q;
		lk_wdata = free_q;
		ls_we    = 1'b0;
		ls_re    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					state_d = acc_state;
				end
			end
			S_WALK: begin
				// one link read per cycle until the target slot is reached
				if (rem_q == '0) begin
					if (cmd_q == CMD_GET) begin
						ls_re   = 1'b1;
						state_d = S_GET_D;
					end else if (cmd_q == CMD_DEL) begin
						lk_re   = 1'b1;
						state_d = S_DEL_P;
					end else begin
						lk_re   = 1'b1;
						state_d = S_INS_C;
					end
				end else begin
					lk_re = 1'b1;
				end
			end
			S_GET_D: begin
				state_d = S_DONE;
			end
			S_INS_A: begin
				// store the value in the free slot, fetch its link to advance the free chain
				ls_we    = 1'b1;
				lk_re    = 1'b1;
				lk_raddr = free_q;
				state_d  = S_INS_B;
			end
			S_INS_B: begin
				if (pos_q == '0) begin
					lk_we    = 1'b1;
					lk_waddr = s_q;
					lk_wdata = head_q;
					state_d  = S_DONE;
				end else begin
					state_d = S_WALK;
				end
			end
			S_INS_C: begin
				lk_we    = 1'b1;
				lk_waddr = s_q;
				lk_wdata = lk_rdata;
				state_d  = S_INS_D;
			end
			S_INS_D: begin
				lk_we    = 1'b1;
				lk_waddr = prev_q;
				lk_wdata = s_q;
				state_d  = S_DONE;
			end
			S_DEL_S: begin
				lk_re    = 1'b1;
				lk_raddr = s_q;
				state_d  = S_DEL_N;
			end
			S_DEL_P: begin
				lk_re    = 1'b1;
				lk_raddr = lk_rdata;
				state_d  = S_DEL_N;
			end
			S_DEL_N: begin
				if (pos_q == '0) begin
					lk_we    = 1'b1;
					lk_waddr = s_q;
					lk_wdata = free_q;
					state_d  = S_DONE;
				end else begin
					lk_we    = 1'b1;
					lk_waddr = prev_q;
					lk_wdata = lk_rdata;
					state_d  = S_DEL_F;
				end
			end
			S_DEL_F: begin
				lk_we    = 1'b1;
				lk_waddr = s_q;
				lk_wdata = free_q;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (rsp_ld) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Link memory array and registered read
	always_ff @(posedge clk) begin
		if (lk_we) begin
			lk_mem[lk_waddr] <= lk_wdata;
		end
		if (lk_re) begin
			lk_rd_s1 <= lk_mem[lk_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lk_vld_q  <= '0;
			lk_vld_s1 <= 1'b0;
			lk_ra_s1  <= '0;
		end else begin
			if (lk_we) begin
				lk_vld_q[lk_waddr] <= 1'b1;
			end
			if (lk_re) begin
				lk_vld_s1 <= lk_vld_q[lk_raddr];
				lk_ra_s1  <= lk_raddr;
			end
		end
	end

	// Entry memory array and registered read
	always_ff @(posedge clk) begin
		if (ls_we) begin
			ls_mem[free_q] <= val_q;
		end
		if (ls_re) begin
			ls_rd_s1 <= ls_mem[walk_cur];
		end
	end

	// List heads, count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			free_q      <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_INS_B: begin
					free_q <= lk_rdata;
					if (pos_q == '0) begin
						head_q <= s_q;
					end
				end
				S_DEL_N: begin
					if (pos_q == '0) begin
						head_q <= lk_rdata;
						free_q <= s_q;
					end
				end
				S_DEL_F: begin
					free_q <= s_q;
				end
				default: begin
				end
			endcase
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
				cnt_q       <= cnt_new;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Command context and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cmd_q        <= cmd.command;
					val_q        <= cmd.value;
					pos_q        <= acc_pos;
					rem_q        <= acc_rem;
					cur_q        <= head_q;
					walk_first_q <= 1'b1;
					s_q          <= head_q;
					res_st_q     <= acc_st;
					res_rd_q     <= acc_rd;
				end
			end
			S_WALK: begin
				walk_first_q <= 1'b0;
				if (rem_q == '0) begin
					prev_q <= walk_cur;
				end else begin
					rem_q <= rem_q - SLOT_W'(1);
				end
			end
			S_GET_D: begin
				res_rd_q <= ls_rd_s1;
			end
			S_INS_A: begin
				s_q <= free_q;
			end
			S_INS_B: begin
				// walk to the predecessor of the insert position
				cur_q        <= head_q;
				walk_first_q <= 1'b1;
				rem_q        <= SLOT_W'(pos_q - CNT_W'(1));
			end
			S_DEL_P: begin
				s_q <= lk_rdata;
			end
			default: begin
			end
		endcase
		if (rsp_ld) begin
			rsp_q.read_value  <= res_rd_q;
			rsp_q.status      <= res_st_q;
			rsp_q.entry_count <= ENTRY_W'(cnt_new);
		end
	end

	// Checks
	a_lk_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(lk_re && lk_we))
		else $error("link memory read and write in the same cycle");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_st_q == ST_FULL) |-> (cnt_q == CNT_W'(CAPACITY)))
		else $error("full status with room left in the list");

	a_del_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && cmd_q == CMD_DEL && res_st_q == ST_DONE) |-> (cnt_q != '0))
		else $error("delete finished on an empty list");

	a_ld_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ld |=> (state_q == S_IDLE && rsp_valid_q && cnt_q == $past(cnt_new)))
		else $error("result load did not update count and return to idle");

endmodule

FILE: tb/sv/tb_indexed_list_engine.sv
// Self-checking testbench for the indexed list engine: directed and random list commands.
`timescale 1ns / 1ps
module tb_indexed_list_engine;
	import ile_pkg::*;

	// Percentage of cycles in which each side holds off.
	localparam int IDLE_PCT      = 26;
	// Cycles with no transfer on either channel before the run is declared hung.
	localparam int STALL_LIMIT   = 4000;
	// Quiet time after the last response: longer than the slowest command.
	localparam int SETTLE_CYCLES = CAPACITY + 32;
	localparam int PHASE_ITEMS   = 100;
	localparam int PHASE_COUNT   = 13;

	// Command codes the block does not use; they must leave the list alone.
	localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

	// Command mix of one random phase.
	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_BALANCED
	} mix_t;

	logic          clk;
	logic          arst_n    = 1'b0;
	logic          cmd_valid = 1'b0;
	logic          cmd_ready;
	ile_cmd_item_t cmd       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	ile_rsp_item_t rsp;

	// Commands waiting for the driver, and responses the list predicts.
	ile_cmd_item_t cmd_queue[$];
	ile_rsp_item_t replies_due[$];
	// Predicted list contents, head first.
	logic signed [VALUE_W-1:0] list_entries[$];

	logic cmd_taken = 1'b0;
	bit   calm      = 1'b0;
	int   issued    = 0;
	int   accepted  = 0;
	int   errors    = 0;
	int   quiet     = 0;

	int n_gets = 0, n_inserts = 0, n_deletes = 0, n_spare = 0;
	int n_full = 0, n_range = 0, n_reached_full = 0, n_reached_empty = 0;

	indexed_list_engine DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Queue one command for the driver.
	task automatic queue_item(input logic [CMD_W-1:0] op, input int idx,
			input logic [VALUE_W-1:0] val);
		ile_cmd_item_t c;
		c.command = op;
		c.index   = INDEX_W'(idx);
		c.value   = val;
		cmd_queue.push_back(c);
		issued++;
	endtask

	// Apply one accepted command to the predicted list and queue the response it must give.
	task automatic apply_command(input ile_cmd_item_t c);
		ile_rsp_item_t r;
		int            idx;
		int            fill;
		bit            in_list;
		fill    = list_entries.size();
		idx     = int'(c.index);
		in_list = idx >= 0 && idx < fill;
		r       = '0;
		r.status = ST_DONE;
		case (c.command)
			CMD_GET: begin
				n_gets++;
				if (in_list) begin
					r.read_value = list_entries[idx];
				end else begin
					r.read_value = RD_INVALID;
					r.status     = ST_RANGE;
				end
			end
			CMD_HEAD, CMD_TAIL, CMD_BEFORE: begin
				n_inserts++;
				// Range check on a positional insert wins over the full check.
				if (c.command == CMD_BEFORE && idx > fill) begin
					r.status = ST_RANGE;
				end else if (fill >= CAPACITY) begin
					r.status = ST_FULL;
				end else if (c.command == CMD_HEAD || (c.command == CMD_BEFORE && idx <= 0)) begin
					list_entries.push_front(c.value);
				end else if (c.command == CMD_TAIL || idx == fill) begin
					list_entries.push_back(c.value);
				end else begin
					list_entries.insert(idx, c.value);
				end
				if (r.status == ST_DONE && list_entries.size() == CAPACITY)
					n_reached_full++;
			end
			CMD_DEL: begin
				n_deletes++;
				if (in_list) begin
					list_entries.delete(idx);
					if (list_entries.size() == 0)
						n_reached_empty++;
				end else begin
					r.status = ST_RANGE;
				end
			end
			default: begin
				n_spare++;
			end
		endcase
		if (r.status == ST_FULL)
			n_full++;
		if (r.status == ST_RANGE)
			n_range++;
		r.entry_count = ENTRY_W'(list_entries.size());
		replies_due.push_back(r);
	endtask

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// Driver and receiver: change inputs on the falling edge only.
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
			rsp_ready <= 1'b0;
		end else begin
			// Hold the current command until its transfer; then maybe present the next one.
			if (!cmd_valid || cmd_taken) begin
				if (cmd_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					cmd_valid <= 1'b1;
					cmd       <= cmd_queue.pop_front();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			rsp_ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	// Monitor: sample both channels on the rising edge, predict, compare, watch for hangs.
	always @(posedge clk) begin : monitor
		ile_rsp_item_t want;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= cmd_valid && cmd_ready;
			if (cmd_valid && cmd_ready) begin
				apply_command(cmd);
				accepted++;
			end
			if (rsp_valid && rsp_ready) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: response with none expected: expected none, actual %0d/%0d/%0d",
						$time, rsp.read_value, rsp.status, rsp.entry_count);
				end else begin
					want = replies_due.pop_front();
					check_field("read_value", want.read_value, rsp.read_value);
					check_field("status", want.status, rsp.status);
					check_field("entry_count", want.entry_count, rsp.entry_count);
				end
			end
			if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= STALL_LIMIT) begin
					$display("%0t: no transfer for %0d cycles, %0d responses outstanding",
						$time, STALL_LIMIT, replies_due.size());
					$display("DONE: errors detected");
					$finish;
				end
			end
		end
	end

	// Stimulus: a directed opening on a short list, then random phases that grow,
	// shrink and churn the list so that both the full and the empty list come up often.
	initial begin : stimulus
		mix_t                 mix;
		int                   fill;
		int                   roll;
		int                   idx;
		logic [CMD_W-1:0]     op;
		logic [VALUE_W-1:0]   val;

		// Empty list: every positional command is out of range.
		queue_item(CMD_GET, 0, 32'h0);
		queue_item(CMD_DEL, 0, 32'h0);
		queue_item(CMD_BEFORE, 1, 32'h1234_5678);
		// Negative positional insert goes to the head.
		queue_item(CMD_BEFORE, -32768, 32'h8000_0000);
		queue_item(CMD_HEAD, 32767, 32'h7FFF_FFFF);
		queue_item(CMD_TAIL, -1, 32'hFFFF_FFFF);
		// Positional insert at the count appends; one in the middle splices.
		queue_item(CMD_BEFORE, 3, 32'h5555_5555);
		queue_item(CMD_BEFORE, 1, 32'hAAAA_AAAA);
		queue_item(CMD_GET, 0, 32'h0);
		queue_item(CMD_GET, 4, 32'h0);
		queue_item(CMD_GET, 5, 32'h0);
		queue_item(CMD_GET, -1, 32'h0);
		queue_item(CMD_GET, 32767, 32'h0);
		queue_item(CMD_GET, -32768, 32'h0);
		// Delete from the middle, the head and the tail, then out of range.
		queue_item(CMD_DEL, 2, 32'h0);
		queue_item(CMD_DEL, 0, 32'h0);
		queue_item(CMD_DEL, 2, 32'h0);
		queue_item(CMD_DEL, -1, 32'h0);
		queue_item(CMD_DEL, 2, 32'h0);
		// Unused codes change nothing.
		queue_item(CMD_SPARE_A, -1, 32'hFFFF_FFFF);
		queue_item(CMD_SPARE_B, 0, 32'h0);
		queue_item(CMD_SPARE_C, -1, 32'hFFFF_FFFF);
		queue_item(CMD_GET, 1, 32'h0);
		queue_item(CMD_TAIL, 0, 32'h0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// Pause the sender until the block has answered everything so far.
			while (accepted != issued || replies_due.size() != 0)
				@(negedge clk);
			case (p % 5)
				0, 1:    mix = MIX_GROW;
				2, 3:    mix = MIX_SHRINK;
				default: mix = MIX_BALANCED;
			endcase
			// One long stretch with neither side idling.
			calm = (p == 5 || p == 6);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// Generate lazily so that indexes track the current list length.
				while (cmd_queue.size() != 0)
					@(posedge clk);
				fill = list_entries.size();
				roll = $urandom_range(99);
				if (roll < (mix == MIX_BALANCED ? 35 : 20)) begin
					op = CMD_GET;
				end else if (roll < (mix == MIX_GROW ? 80 : mix == MIX_SHRINK ? 40 : 65)) begin
					case ($urandom_range(2))
						0:       op = CMD_HEAD;
						1:       op = CMD_TAIL;
						default: op = CMD_BEFORE;
					endcase
				end else if (roll < 97) begin
					op = CMD_DEL;
				end else begin
					case ($urandom_range(2))
						0:       op = CMD_SPARE_A;
						1:       op = CMD_SPARE_B;
						default: op = CMD_SPARE_C;
					endcase
				end
				// Mostly in-range positions, with the boundaries and wild values mixed in.
				roll = $urandom_range(99);
				if (roll < 70) begin
					if (op == CMD_BEFORE)
						idx = $urandom_range(fill, 0);
					else
						idx = (fill == 0) ? 0 : $urandom_range(fill - 1, 0);
				end else if (roll < 80) begin
					idx = fill;
				end else if (roll < 85) begin
					idx = fill + 1;
				end else if (roll < 90) begin
					idx = -1;
				end else begin
					idx = int'($signed(INDEX_W'($urandom())));
				end
				case ($urandom_range(9))
					0:       val = 32'h8000_0000;
					1:       val = 32'h7FFF_FFFF;
					2:       val = $urandom_range(15);
					default: val = $urandom();
				endcase
				queue_item(op, idx, val);
			end
		end
		calm = 1'b0;

		// Drain, then give any stray response time to show up.
		while (accepted != issued || replies_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Covered %0d commands: %0d gets, %0d inserts, %0d deletes, %0d unused codes.",
			accepted, n_gets, n_inserts, n_deletes, n_spare);
		$display("Saw %0d full rejects, %0d range rejects; list filled %0d times, emptied %0d times.",
			n_full, n_range, n_reached_full, n_reached_empty);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
